// ----- hdl/bth_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_pkg
// shared types, constants and the entry ordering for the bounded top-b store
// ----------------------------------------------------------------------------
package bth_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int WEIGHT_W    = 32;
  localparam int ID_W        = 31;
  localparam int COUNT_W     = 5;
  localparam int CAP_W       = 5;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [ID_W-1:0]     id;
  } entry_t;

  // per-request control broadcast to every cell
  typedef struct packed {
    logic   load;     // request accepted this cycle
    logic   replace;  // store full: drop the minimum, then insert
    entry_t offer;    // offered entry
  } cell_ctrl_t;

  // ordering by weight, then id on ties, both unsigned
  function automatic logic entry_less(entry_t a, entry_t b);
    return (a.weight < b.weight) || ((a.weight == b.weight) && (a.id < b.id));
  endfunction

endpackage

// ----- hdl/bth_offer_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_offer_if
// request channel carrying one offered entry
// ----------------------------------------------------------------------------
interface bth_offer_if import bth_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic [ID_W-1:0]     entry_id;

  modport source (output valid, output weight, output entry_id, input ready);
  modport sink   (input valid, input weight, input entry_id, output ready);
endinterface

// ----- hdl/bth_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_result_if
// result channel: count, full flag, minimum and evicted entry
// ----------------------------------------------------------------------------
interface bth_result_if import bth_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  count;
  logic                is_full;
  logic [WEIGHT_W-1:0] min_weight;
  logic [ID_W-1:0]     min_id;
  logic                evicted_valid;
  logic [WEIGHT_W-1:0] evicted_weight;
  logic [ID_W-1:0]     evicted_id;

  modport source (output valid, output count, output is_full, output min_weight,
                  output min_id, output evicted_valid, output evicted_weight,
                  output evicted_id, input ready);
  modport sink   (input valid, input count, input is_full, input min_weight,
                  input min_id, input evicted_valid, input evicted_weight,
                  input evicted_id, output ready);
endinterface

// ----- hdl/bth_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_cell
// one slot of the sorted chain: compares the offer and shifts with neighbors
// ----------------------------------------------------------------------------
module bth_cell import bth_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       first,
  input  entry_t     left_data,
  input  logic       left_lt,
  input  entry_t     right_data,
  input  logic       right_lt,
  output entry_t     data,
  output logic       lt,
  output entry_t     data_next
);

  // offer sorts before this slot (empty slots count as larger)
  assign lt = !occupied || entry_less(ctrl.offer, data);

  always_comb begin
    if (ctrl.replace) begin
      // slot 0 drops out, upper entries slide down around the offer
      if (!right_lt) begin
        data_next = right_data;
      end else if (first || !lt) begin
        data_next = ctrl.offer;
      end else begin
        data_next = data;
      end
    end else begin
      // insert: entries above the offer slide up
      if (!lt) begin
        data_next = data;
      end else if (left_lt) begin
        data_next = left_data;
      end else begin
        data_next = ctrl.offer;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= data_next;
    end
  end

endmodule

// ----- hdl/bounded_top_b_min_heap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_top_b_min_heap
// bounded store of (weight, id) entries kept sorted in a chain of cells
// ----------------------------------------------------------------------------
//  channel   dir  handshake      contents
//  offer     in   valid/ready    weight, entry_id
//  result    out  valid/ready    count, is_full, min, evicted entry
//  cfg       in   cfg_wr_en      capacity (5 bits)
//
//  one request per cycle while the result register is free or draining: every
//  cell compares the offer in parallel and takes its own, its left or its right
//  neighbor's entry in the same cycle; the result appears in the output register
//  in the cycle after acceptance; a new request is taken while the result
//  register is empty or being read, never while rst is high
//  reset clears the count and sets capacity to 1; the cells are not cleared
// ----------------------------------------------------------------------------
module bounded_top_b_min_heap import bth_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  bth_offer_if.sink        offer,
  bth_result_if.source     result,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  logic [CAP_W-1:0]   capacity;
  logic [COUNT_W-1:0] held_count;
  logic [COUNT_W-1:0] held_count_next;
  logic [COUNT_W-1:0] cap_eff;
  logic               accept;
  logic               append;
  logic               full_next;
  cell_ctrl_t         ctrl;

  // chain wiring
  entry_t cell_data      [MAX_ENTRIES];
  entry_t cell_data_next [MAX_ENTRIES];
  logic   cell_lt        [MAX_ENTRIES];

  // clamp capacity into 1..MAX_ENTRIES
  always_comb begin
    if (capacity == '0) begin
      cap_eff = COUNT_W'(1);
    end else if (COUNT_W'(capacity) > COUNT_W'(MAX_ENTRIES)) begin
      cap_eff = COUNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = COUNT_W'(capacity);
    end
  end

  // request is taken whenever the result register is free or draining, not in reset
  assign offer.ready = !rst && (!result.valid || result.ready);
  assign accept      = offer.valid && offer.ready;

  // below capacity the offer is added, otherwise the minimum is replaced
  assign append          = held_count < cap_eff;
  assign held_count_next = append ? held_count + COUNT_W'(1) : held_count;
  assign full_next       = held_count_next >= cap_eff;

  assign ctrl.load         = accept;
  assign ctrl.replace      = !append;
  assign ctrl.offer.weight = offer.weight;
  assign ctrl.offer.id     = offer.entry_id;

  // sorted chain, smallest entry in cell 0
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t left_data;
    logic   left_lt;
    entry_t right_data;
    logic   right_lt;

    if (i == 0) begin : g_head
      assign left_data = '0;
      assign left_lt   = 1'b0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
      assign left_lt   = cell_lt[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_data = '0;
      assign right_lt   = 1'b1;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
      assign right_lt   = cell_lt[i+1];
    end

    bth_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (held_count > COUNT_W'(i)),
      .first      (i == 0),
      .left_data  (left_data),
      .left_lt    (left_lt),
      .right_data (right_data),
      .right_lt   (right_lt),
      .data       (cell_data[i]),
      .lt         (cell_lt[i]),
      .data_next  (cell_data_next[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAP_W'(1);
      held_count   <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (accept) begin
        held_count   <= held_count_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // result register: minimum comes from cell 0's new value
  always_ff @(posedge clk) begin
    if (accept) begin
      result.count          <= held_count_next;
      result.is_full        <= full_next;
      result.min_weight     <= full_next ? cell_data_next[0].weight : '0;
      result.min_id         <= full_next ? cell_data_next[0].id : '0;
      result.evicted_valid  <= !append;
      result.evicted_weight <= append ? '0 : cell_data[0].weight;
      result.evicted_id     <= append ? '0 : cell_data[0].id;
    end
  end

endmodule
